/* hdl/sprite_lz_decompressor_core_assert.svh */
// Assertion macros for the sprite LZ decompressor checker.
// No dependencies; include by bare file name.
`ifndef SPRITE_LZ_DECOMPRESSOR_CORE_ASSERT_SVH
`define SPRITE_LZ_DECOMPRESSOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SLZD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slzd check failed");

// Next-cycle implication, off during reset.
`define SLZD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slzd check failed");

// Next-cycle implication, live through reset.
`define SLZD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slzd check failed");

`endif

/* hdl/slzd_pkg.sv */
// Shared constants and types for the sprite LZ decompressor.
// No dependencies.
`default_nettype none
package slzd_pkg;

  localparam int WINDOW_DEPTH = 2048;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int SIZE_W       = 16;
  localparam int DIST_W       = 11;
  localparam int LEN_W        = 5;

  localparam logic [BYTE_W-1:0] TYPE_RAW_HIDDEN = 8'hFF;
  localparam int                TYPE_RAW_BIT    = 1;
  localparam logic [2:0]        HEADER_BYTES    = 3'd7;
  localparam logic [7:0]        LIT_ZERO_RUN    = 8'd128;
  localparam logic [LEN_W-1:0]  MAX_COPY        = 5'd16;
  localparam logic [5:0]        COPY_BASE       = 6'd32;
  localparam int                CTRL_REF_BIT    = 7;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } win_wr_t;

endpackage
`default_nettype wire

/* hdl/slzd_if.sv */
// Handshake channels for compressed input and decompressed output bytes.
// Depends on slzd_pkg for field widths.
`default_nettype none
interface slzd_in_if;
  logic                        valid;
  logic                        ready;
  logic [slzd_pkg::BYTE_W-1:0] in_byte;
  logic                        start_req;
  logic [slzd_pkg::SIZE_W-1:0] sprite_size;

  modport source (output valid, in_byte, start_req, sprite_size, input ready);
  modport sink (input valid, in_byte, start_req, sprite_size, output ready);
endinterface

interface slzd_out_if;
  logic                        valid;
  logic                        ready;
  logic [slzd_pkg::BYTE_W-1:0] out_byte;
  logic                        last_out;
  logic                        overrun;

  modport source (output valid, out_byte, last_out, overrun, input ready);
  modport sink (input valid, out_byte, last_out, overrun, output ready);
endinterface
`default_nettype wire

/* hdl/slzd_window.sv */
// History window memory: one write port, one registered read port.
// Depends on slzd_pkg.
`default_nettype none
module slzd_window (
  input  wire                              clk,
  input  slzd_pkg::win_wr_t                wr,
  input  wire                              rd_en,
  input  wire  [slzd_pkg::WIN_AW-1:0]      rd_addr,
  output logic [slzd_pkg::BYTE_W-1:0]      rd_data
);
  import slzd_pkg::*;

  logic [BYTE_W-1:0] mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/sprite_lz_decompressor_core.sv */
// Sprite LZ decompressor top level: byte decoder, sequencer and output register.
// Depends on slzd_pkg, slzd_in_if, slzd_out_if and slzd_window.
`default_nettype none
// After reset the block sweeps its 2048-byte history window to zero with input
// ready low. Then it accepts input transactions in S_IDLE; a byte that produces
// output (type other than 8'hFF, header, raw or literal) is then emitted from
// S_EMIT, a control byte emits none, and a back-reference distance byte copies 1
// to 16 bytes, each first read from the window memory through its registered
// read port in S_READ and then emitted and written back in S_COPY. Output
// stalls hold the sequencer; a finished byte waits in the output register while
// the next input transaction is accepted.
module sprite_lz_decompressor_core (
  input wire         clk,
  input wire         rst,
  slzd_in_if.sink    in_stream,
  slzd_out_if.source out_stream
);
  import slzd_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EMIT, S_READ, S_COPY} seq_t;
  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_RAW, PH_CONTROL, PH_LITERAL, PH_DIST
  } phase_t;

  seq_t              state;
  phase_t            phase;
  logic [WIN_AW-1:0] wp;
  logic [WIN_AW-1:0] clr_addr;
  logic [SIZE_W-1:0] remaining;
  logic              raw_mode;
  logic [2:0]        header_left;
  logic [7:0]        literal_left;
  logic [2:0]        pend_hi;
  logic [LEN_W-1:0]  pend_len;
  logic [BYTE_W-1:0] byte_q;
  logic              more_q;
  logic [DIST_W-1:0] dist_q;
  logic [LEN_W-1:0]  copy_left;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              last_out;
  logic              overrun;

  logic              in_fire;
  logic              slot_free;
  logic              emit_fire;
  logic [BYTE_W-1:0] emit_data;
  logic              emit_more;
  logic              emit_last;
  logic [BYTE_W-1:0] b;
  logic [2:0]        header_next;
  logic [7:0]        literal_next;
  logic [LEN_W-1:0]  copy_len;
  logic [BYTE_W-1:0] rd_data;
  win_wr_t           win_wr;

  assign in_stream.ready     = (state == S_IDLE);
  assign in_fire             = in_stream.valid && in_stream.ready;
  assign b                   = in_stream.in_byte;
  assign header_next         = header_left - 3'd1;
  assign literal_next        = literal_left - 8'd1;
  assign copy_len            = (pend_len > MAX_COPY) ? MAX_COPY : pend_len;

  assign slot_free = !out_valid || out_stream.ready;
  assign emit_fire = ((state == S_EMIT) || (state == S_COPY)) && slot_free;
  assign emit_data = (state == S_COPY) ? rd_data : byte_q;
  assign emit_more = (state == S_COPY) ? (copy_left != 5'd1) : more_q;
  assign emit_last = (remaining == 16'd1);

  always_comb begin
    win_wr.en   = (state == S_CLEAR) || emit_fire;
    win_wr.addr = (state == S_CLEAR) ? clr_addr : wp;
    win_wr.data = (state == S_CLEAR) ? '0 : emit_data;
  end

  slzd_window u_window (
    .clk     (clk),
    .wr      (win_wr),
    .rd_en   (state == S_READ),
    .rd_addr (wp - WIN_AW'(dist_q)),
    .rd_data (rd_data)
  );

  assign out_stream.valid    = out_valid;
  assign out_stream.out_byte = out_byte;
  assign out_stream.last_out = last_out;
  assign out_stream.overrun  = overrun;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      phase        <= PH_IDLE;
      wp           <= '0;
      clr_addr     <= '0;
      remaining    <= '0;
      raw_mode     <= 1'b0;
      header_left  <= '0;
      literal_left <= '0;
      pend_hi      <= '0;
      pend_len     <= '0;
      copy_left    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_stream.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WIN_AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            byte_q <= b;
            if (in_stream.start_req) begin
              remaining    <= in_stream.sprite_size;
              header_left  <= '0;
              literal_left <= '0;
              pend_hi      <= '0;
              pend_len     <= '0;
              if (in_stream.sprite_size == '0) begin
                phase <= PH_IDLE;
              end else if (b == TYPE_RAW_HIDDEN) begin
                raw_mode <= 1'b1;
                phase    <= PH_RAW;
              end else begin
                raw_mode    <= b[TYPE_RAW_BIT];
                header_left <= HEADER_BYTES;
                phase       <= PH_HEADER;
                more_q      <= 1'b1;
                state       <= S_EMIT;
              end
            end else begin
              case (phase)
                PH_HEADER: begin
                  header_left <= header_next;
                  more_q      <= (header_next != '0);
                  state       <= S_EMIT;
                  if (header_next == '0) begin
                    phase <= raw_mode ? PH_RAW : PH_CONTROL;
                  end
                end
                PH_RAW: begin
                  more_q <= 1'b0;
                  state  <= S_EMIT;
                end
                PH_CONTROL: begin
                  if (!b[CTRL_REF_BIT]) begin
                    literal_left <= (b == '0) ? LIT_ZERO_RUN : b;
                    phase        <= PH_LITERAL;
                  end else begin
                    pend_len <= LEN_W'(COPY_BASE - {1'b0, b[7:3]});
                    pend_hi  <= b[2:0];
                    phase    <= PH_DIST;
                  end
                end
                PH_LITERAL: begin
                  literal_left <= literal_next;
                  more_q       <= (literal_next != '0);
                  state        <= S_EMIT;
                  if (literal_next == '0) begin
                    phase <= PH_CONTROL;
                  end
                end
                PH_DIST: begin
                  dist_q    <= {pend_hi, b};
                  copy_left <= copy_len;
                  pend_len  <= '0;
                  pend_hi   <= '0;
                  phase     <= PH_CONTROL;
                  if (copy_len != '0) begin
                    state <= S_READ;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end

        S_EMIT: begin
          if (emit_fire) begin
            state <= S_IDLE;
          end
        end

        S_READ: begin
          state <= S_COPY;
        end

        S_COPY: begin
          if (emit_fire) begin
            copy_left <= copy_left - 5'd1;
            state     <= (emit_last || copy_left == 5'd1) ? S_IDLE : S_READ;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (emit_fire) begin
        wp        <= wp + WIN_AW'(1);
        remaining <= remaining - 16'd1;
        out_valid <= 1'b1;
        out_byte  <= emit_data;
        last_out  <= emit_last;
        overrun   <= emit_last && emit_more;
        if (emit_last) begin
          phase <= PH_IDLE;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/slzd_checker.sv */
// Port-level checks for the sprite LZ decompressor, bound to its top level.
// Depends on sprite_lz_decompressor_core_assert.svh.
`default_nettype none
`include "sprite_lz_decompressor_core_assert.svh"
module slzd_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       last_out,
  input wire       overrun
);

  `SLZD_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clk, rst, !in_ready)
  `SLZD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_out) && $stable(overrun))
  `SLZD_ASSERT_IMPL(a_overrun_last, clk, rst, out_valid && overrun, last_out)
  `SLZD_ASSERT_IMPL(a_clear_no_output, clk, rst, !in_ready && $past(rst), !out_valid)

endmodule

bind sprite_lz_decompressor_core slzd_checker u_slzd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_byte  (out_stream.out_byte),
  .last_out  (out_stream.last_out),
  .overrun   (out_stream.overrun)
);
`default_nettype wire
